@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, quiet in reset; default clock clk_i.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and reset.
`define MFKE_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Default form: block clock and active-low reset.
`define MFKE_ASSERT(label, prop, msg) \
  `MFKE_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

@@ design/mfke_pkg.sv @@
// ----------------------------------------------------------------------------
// mfke_pkg
// Types, masks and make-code table for the modifier key event translator.
// ----------------------------------------------------------------------------
package mfke_pkg;

  localparam int unsigned NumMods  = 4;
  localparam int unsigned NumSlots = 2 * NumMods;
  localparam int unsigned FlagsW   = 21;
  localparam int unsigned SlotW    = $clog2(NumSlots);

  localparam logic [1:0] ModShift   = 2'd0;
  localparam logic [1:0] ModControl = 2'd1;
  localparam logic [1:0] ModAlt     = 2'd2;
  localparam logic [1:0] ModCommand = 2'd3;

  localparam logic SideLeft  = 1'b0;
  localparam logic SideRight = 1'b1;

  localparam logic OpUpdate = 1'b0;
  localparam logic OpReset  = 1'b1;

  // Group flag per modifier.
  localparam logic [NumMods-1:0][FlagsW-1:0] GroupMask = '{
    21'h100000, 21'h080000, 21'h040000, 21'h020000
  };

  // Side sub-masks, [modifier][side].
  localparam logic [NumMods-1:0][1:0][FlagsW-1:0] SideMask = '{
    '{21'h100110, 21'h100108},
    '{21'h000140, 21'h000120},
    '{21'h002100, 21'h000101},
    '{21'h000104, 21'h000102}
  };

  typedef enum logic [2:0] {
    KindPress       = 3'd0,
    KindRelease     = 3'd1,
    KindMenuPress   = 3'd2,
    KindMenuRelease = 3'd3,
    KindMarker      = 3'd4
  } event_kind_e;

  typedef struct packed {
    logic [1:0] len;
    logic [7:0] first;
    logic [7:0] second;
  } code_t;

  // Events of one item, one slot per modifier side (id*2 + side).
  typedef struct packed {
    logic        [NumSlots-1:0] valid;
    event_kind_e [NumSlots-1:0] kind;
    logic                       combo;
  } event_set_t;

  // PS/2 set-2 make code per modifier side.
  function automatic code_t key_code(logic [1:0] id, logic side);
    code_t c;
    c = '0;
    unique case ({id, side})
      {ModShift,   SideLeft }: c = '{2'd1, 8'h12, 8'h00};
      {ModShift,   SideRight}: c = '{2'd1, 8'h59, 8'h00};
      {ModControl, SideLeft }: c = '{2'd1, 8'h14, 8'h00};
      {ModControl, SideRight}: c = '{2'd2, 8'hE0, 8'h14};
      {ModAlt,     SideLeft }: c = '{2'd1, 8'h11, 8'h00};
      {ModAlt,     SideRight}: c = '{2'd2, 8'hE0, 8'h11};
      {ModCommand, SideLeft }: c = '{2'd2, 8'hE0, 8'h1F};
      {ModCommand, SideRight}: c = '{2'd2, 8'hE0, 8'h27};
      default:                 c = '0;
    endcase
    return c;
  endfunction

endpackage

@@ design/modifier_flags_to_key_events.sv @@
// ----------------------------------------------------------------------------
// modifier_flags_to_key_events
// Host modifier flags to PS/2 set-2 key events, one run of events per item.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tuser: opcode; tdata: flags, send_release
//  m_*     | out | m_tvalid/m_tready  | tuser: event_kind; tdata: id..combo; tlast
//  cfg_*   | in  | cfg_valid_i/ready  | cfg_data_i: two_button_mouse
//
//  An item causes 0 to 8 events plus its end marker, so 1 to 9 in all; the
//  output register passes on one event per cycle while m_tready does not stall.
//  The held state updates on accept, so the next item is taken in the cycle
//  its predecessor's marker moves to the output register.
//  Reset clears the held state, the config bit and both valid flags.
//  A stalled m_tready holds the output register and back-pressures s_tready.
// ----------------------------------------------------------------------------
module modifier_flags_to_key_events import mfke_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [20:0] modifier_flags, [21] send_release, [23:22] zero
  input  logic        s_tuser,   // [0] opcode
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [1:0] modifier_id, [2] key_side, [4:3] code_length,
                                 // [12:5] code_first, [20:13] code_second,
                                 // [21] special_combo, [23:22] zero
  output logic [2:0]  m_tuser,   // [2:0] event_kind
  output logic        m_tlast,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  logic                    two_button_q;
  logic [NumMods-1:0][1:0] held_q;
  logic [NumMods-1:0][1:0] held_d;
  event_set_t              events;
  logic                    s_accept;

  event_kind_e kind;
  logic [1:0]  id;
  logic        side;
  code_t       code;
  logic        combo;

  assign s_accept    = s_tvalid && s_tready;
  assign cfg_ready_o = 1'b1;

  // Config bit; the user must write it only while idle (not enforced).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      two_button_q <= 1'b0;
    end else if (cfg_valid_i) begin
      two_button_q <= cfg_data_i;
    end
  end

  // Held sides move on at accept; events wait in the drain stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (s_accept) begin
      held_q <= held_d;
    end
  end

  mfke_eval u_eval (
    .opcode_i       (s_tuser),
    .flags_i        (s_tdata[FlagsW-1:0]),
    .send_release_i (s_tdata[FlagsW]),
    .two_button_i   (two_button_q),
    .held_i         (held_q),
    .held_o         (held_d),
    .events_o       (events)
  );

  mfke_drain u_drain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (s_accept),
    .events_i (events),
    .ready_o  (s_tready),
    .valid_o  (m_tvalid),
    .taken_i  (m_tready),
    .kind_o   (kind),
    .id_o     (id),
    .side_o   (side),
    .code_o   (code),
    .combo_o  (combo),
    .last_o   (m_tlast)
  );

  assign m_tuser = kind;
  assign m_tdata = {2'b00, combo, code.second, code.first, code.len, side, id};

endmodule

@@ design/mfke_eval.sv @@
// ----------------------------------------------------------------------------
// mfke_eval
// Decodes one item against the held state: event slots and next state.
// ----------------------------------------------------------------------------
module mfke_eval import mfke_pkg::*; (
  input  logic                      opcode_i,
  input  logic [FlagsW-1:0]         flags_i,
  input  logic                      send_release_i,
  input  logic                      two_button_i,
  input  logic [NumMods-1:0][1:0]   held_i,
  output logic [NumMods-1:0][1:0]   held_o,
  output event_set_t                events_o
);

  always_comb begin
    logic [1:0] st;
    logic       grp;
    logic       menu_mod;
    events_o = '0;
    for (int k = 0; k < NumMods; k++) begin
      st       = held_i[k];
      grp      = |(flags_i & GroupMask[k]);
      menu_mod = (k == int'(ModCommand)) && two_button_i;
      if (opcode_i == OpReset) begin
        for (int s = 0; s < 2; s++) begin
          if (send_release_i && st[s]) begin
            events_o.valid[2*k+s] = 1'b1;
            events_o.kind[2*k+s]  = KindRelease;
          end
        end
        st = 2'b00;
      end else if (grp) begin
        if (menu_mod && st == 2'b00) begin
          st = 2'b11;
          events_o.valid[2*k] = 1'b1;
          events_o.kind[2*k]  = KindMenuPress;
        end else begin
          for (int s = 0; s < 2; s++) begin
            if ((flags_i & SideMask[k][s]) == SideMask[k][s] && !st[s]) begin
              st[s] = 1'b1;
              events_o.valid[2*k+s] = 1'b1;
              events_o.kind[2*k+s]  = KindPress;
            end
          end
        end
      end else if (st != 2'b00) begin
        if (menu_mod) begin
          events_o.valid[2*k] = 1'b1;
          events_o.kind[2*k]  = KindMenuRelease;
        end else begin
          for (int s = 0; s < 2; s++) begin
            if (st[s]) begin
              events_o.valid[2*k+s] = 1'b1;
              events_o.kind[2*k+s]  = KindRelease;
            end
          end
        end
        st = 2'b00;
      end
      held_o[k] = st;
    end
    events_o.combo = (held_o[ModControl] != 2'b00) && (held_o[ModCommand] != 2'b00);
  end

endmodule

@@ design/mfke_drain.sv @@
// ----------------------------------------------------------------------------
// mfke_drain
// Pending event and output registers; one event per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfke_drain import mfke_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  event_set_t  events_i,
  output logic        ready_o,
  output logic        valid_o,
  input  logic        taken_i,
  output event_kind_e kind_o,
  output logic [1:0]  id_o,
  output logic        side_o,
  output code_t       code_o,
  output logic        combo_o,
  output logic        last_o
);

  logic       pend_valid_q;
  event_set_t pend_q;
  logic       out_valid_q;
  event_kind_e kind_q;
  logic [1:0] id_q;
  logic       side_q;
  code_t      code_q;
  logic       combo_q;
  logic       last_q;

  logic             out_free;
  logic             adv;
  logic             has_event;
  logic             marker_load;
  logic             out_menu;
  logic [SlotW-1:0] idx;

  // Lowest pending slot goes first.
  always_comb begin
    idx = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (pend_q.valid[i]) idx = SlotW'(i);
    end
  end

  assign out_free    = !out_valid_q || taken_i;
  assign adv         = pend_valid_q && out_free;
  assign has_event   = |pend_q.valid;
  assign marker_load = adv && !has_event;
  assign ready_o     = !pend_valid_q || marker_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
    end else if (load_i) begin
      pend_valid_q <= 1'b1;
      pend_q       <= events_i;
    end else if (adv) begin
      if (has_event) pend_q.valid[idx] <= 1'b0;
      else           pend_valid_q      <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= pend_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (has_event) begin
        kind_q  <= pend_q.kind[idx];
        side_q  <= 1'b0;
        combo_q <= 1'b0;
        last_q  <= 1'b0;
        id_q    <= idx[SlotW-1:1];
        if (pend_q.kind[idx] == KindMenuPress || pend_q.kind[idx] == KindMenuRelease) begin
          code_q <= '0;
        end else begin
          side_q <= idx[0];
          code_q <= key_code(idx[SlotW-1:1], idx[0]);
        end
      end else begin
        kind_q  <= KindMarker;
        id_q    <= '0;
        side_q  <= 1'b0;
        code_q  <= '0;
        combo_q <= pend_q.combo;
        last_q  <= 1'b1;
      end
    end
  end

  assign out_menu = (kind_q == KindMenuPress) || (kind_q == KindMenuRelease);

  assign valid_o = out_valid_q;
  assign kind_o  = kind_q;
  assign id_o    = id_q;
  assign side_o  = side_q;
  assign code_o  = code_q;
  assign combo_o = combo_q;
  assign last_o  = last_q;

  `MFKE_ASSERT(a_last_is_marker, out_valid_q && last_q |-> kind_q == KindMarker, "stray last")
  `MFKE_ASSERT(a_load_sets_pend, load_i |=> pend_valid_q, "loaded item not pending")
  `MFKE_ASSERT(a_marker_ends_run, marker_load && !load_i |=> !pend_valid_q, "run not closed")
  `MFKE_ASSERT(a_menu_on_command, out_valid_q && out_menu |-> id_q == ModCommand, "menu off command")

endmodule

@@ tb/modifier_flags_to_key_events_tb.sv @@
// ----------------------------------------------------------------------------
// modifier_flags_to_key_events_tb
// Self-checking bench for the modifier flags to key event translator. Items go
// in on the s_* stream. A local predictor tracks the held sides of shift,
// control, alt and command and the menu-button mode, and queues the key events
// and the end marker that each accepted item should produce. Each m_* output
// transaction is checked field by field against the oldest queued event.
// ----------------------------------------------------------------------------
module modifier_flags_to_key_events_tb;
  import mfke_pkg::*;

  // One expected or observed output transaction.
  typedef struct packed {
    event_kind_e kind;
    logic [1:0]  id;
    logic        side;
    logic [1:0]  len;
    logic [7:0]  first;
    logic [7:0]  second;
    logic        combo;
    logic        last;
  } key_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;

  // Predictor state: held sides per modifier (bit0 left, bit1 right), mode bit.
  logic [1:0]  held_sides [4];
  logic        menu_mode;
  key_event_t  pending_events [$];
  key_event_t  want;

  // Stimulus shaping; idle_on is shared by the sender and the receiver.
  bit          idle_on;
  int          hold_off;
  int          stall_left;

  int          errors;
  int          items_sent;
  int          events_checked;
  int          menu_events;
  int          reset_items;
  int          cfg_writes;

  // 2 time unit clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  modifier_flags_to_key_events dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic logic [20:0] group_flag(int k);
    return 21'h020000 << k;
  endfunction

  // Sub-mask that must be fully present for a side to count as pressed.
  function automatic logic [20:0] side_mask(int k, int s);
    case (k * 2 + s)
      0:       return 21'h000102;  // shift L
      1:       return 21'h000104;  // shift R
      2:       return 21'h000101;  // control L
      3:       return 21'h002100;  // control R
      4:       return 21'h000120;  // alt L
      5:       return 21'h000140;  // alt R
      6:       return 21'h100108;  // command L
      default: return 21'h100110;  // command R
    endcase
  endfunction

  // Queue one event; key events carry their PS/2 set-2 make code, menu events
  // and the marker carry zero codes.
  function automatic void push_event(event_kind_e kind, logic [1:0] id, logic side,
                                     logic combo);
    key_event_t ev;
    ev = '0;
    ev.kind  = kind;
    ev.id    = id;
    ev.side  = side;
    ev.combo = combo;
    ev.last  = (kind == KindMarker);
    if (kind == KindPress || kind == KindRelease) begin
      case ({id, side})
        {ModShift,   SideLeft }: {ev.len, ev.first, ev.second} = {2'd1, 8'h12, 8'h00};
        {ModShift,   SideRight}: {ev.len, ev.first, ev.second} = {2'd1, 8'h59, 8'h00};
        {ModControl, SideLeft }: {ev.len, ev.first, ev.second} = {2'd1, 8'h14, 8'h00};
        {ModControl, SideRight}: {ev.len, ev.first, ev.second} = {2'd2, 8'hE0, 8'h14};
        {ModAlt,     SideLeft }: {ev.len, ev.first, ev.second} = {2'd1, 8'h11, 8'h00};
        {ModAlt,     SideRight}: {ev.len, ev.first, ev.second} = {2'd2, 8'hE0, 8'h11};
        {ModCommand, SideLeft }: {ev.len, ev.first, ev.second} = {2'd2, 8'hE0, 8'h1F};
        default:                 {ev.len, ev.first, ev.second} = {2'd2, 8'hE0, 8'h27};
      endcase
    end
    if (kind == KindMenuPress || kind == KindMenuRelease) menu_events++;
    pending_events.push_back(ev);
  endfunction

  // Work out the run of events one accepted item causes, in modifier order.
  function automatic void predict_key_events(logic op, logic [20:0] flags, logic rel);
    logic [1:0] st;
    logic [1:0] id;
    for (int k = 0; k < 4; k++) begin
      st = held_sides[k];
      id = k[1:0];
      if (op == OpReset) begin
        // releases for every held side, command too, whatever the mode
        if (rel) begin
          for (int s = 0; s < 2; s++)
            if (st[s]) push_event(KindRelease, id, s[0], 1'b0);
        end
        st = 2'b00;
      end else if ((flags & group_flag(k)) != 0) begin
        if (id == ModCommand && menu_mode && st == 2'b00) begin
          st = 2'b11;
          push_event(KindMenuPress, ModCommand, 1'b0, 1'b0);
        end else begin
          // partly held command falls back to the per-side rules
          for (int s = 0; s < 2; s++) begin
            if ((flags & side_mask(k, s)) == side_mask(k, s) && !st[s]) begin
              st[s] = 1'b1;
              push_event(KindPress, id, s[0], 1'b0);
            end
          end
        end
      end else if (st != 2'b00) begin
        if (id == ModCommand && menu_mode) begin
          st = 2'b00;
          push_event(KindMenuRelease, ModCommand, 1'b0, 1'b0);
        end else begin
          for (int s = 0; s < 2; s++) begin
            if (st[s]) begin
              st[s] = 1'b0;
              push_event(KindRelease, id, s[0], 1'b0);
            end
          end
        end
      end
      held_sides[k] = st;
    end
    push_event(KindMarker, 2'd0, 1'b0,
               (held_sides[ModControl] != 2'b00) && (held_sides[ModCommand] != 2'b00));
  endfunction

  // --------------------------------------------------------------------------
  // Driving helpers
  // --------------------------------------------------------------------------

  // Idle length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item and hold it until accepted. tvalid stays high on return so
  // that a following item can go out back to back.
  task automatic send_item(logic op, logic [20:0] flags, logic rel);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_tvalid = 1'b0;
      s_tdata  = 24'($urandom);  // junk while idle
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_tvalid = 1'b1;
    s_tuser  = op;                      // [0] opcode
    s_tdata  = {2'b00, rel, flags};     // [20:0] flags, [21] send_release
    do @(posedge clk_i); while (!s_tready);
    predict_key_events(op, flags, rel);
    items_sent++;
    if (op == OpReset) reset_items++;
  endtask

  // Drop tvalid and let every queued event come out; the block is idle after
  // its last marker, and the extra wait after that is margin.
  task automatic wait_drained();
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(logic value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    menu_mode = value;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted down here
  // --------------------------------------------------------------------------
  initial begin
    m_tready   = 1'b0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        m_tready = 1'b0;
        hold_off--;
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
        if (idle_on) stall_left = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected output transaction: kind %0d tdata 0x%06h", m_tuser, m_tdata);
        errors++;
      end else begin
        want = pending_events.pop_front();
        events_checked++;
        // m_tdata: [1:0] id, [2] side, [4:3] len, [12:5] first, [20:13] second,
        //          [21] combo; m_tuser: kind
        check_field("event_kind",    want.kind,   m_tuser);
        check_field("modifier_id",   want.id,     m_tdata[1:0]);
        check_field("key_side",      want.side,   m_tdata[2]);
        check_field("code_length",   want.len,    m_tdata[4:3]);
        check_field("code_first",    want.first,  m_tdata[12:5]);
        check_field("code_second",   want.second, m_tdata[20:13]);
        check_field("special_combo", want.combo,  m_tdata[21]);
        check_field("last",          want.last,   m_tlast);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Per modifier: left press, right press added, then side bits alone release both
  // (not command: its masks hold its group flag). Also right-only and partial masks.
  task automatic test_single_modifiers();
    write_mode(1'b0);
    for (int k = 0; k < 4; k++) begin
      send_item(OpUpdate, group_flag(k) | side_mask(k, 0), 1'b0);
      send_item(OpUpdate, group_flag(k) | side_mask(k, 0) | side_mask(k, 1), 1'b0);
      send_item(OpUpdate, side_mask(k, 0) | side_mask(k, 1), 1'b0);
    end
    send_item(OpUpdate, group_flag(ModShift) | side_mask(ModShift, 1), 1'b0);
    send_item(OpUpdate, group_flag(ModAlt) | 21'h000100, 1'b0);  // partial mask only
    send_item(OpUpdate, 21'h000000, 1'b0);
  endtask

  // All ones presses every side (9 results, combo set), again nothing new,
  // then all zeros releases all eight.
  task automatic test_flag_extremes();
    send_item(OpUpdate, 21'h1FFFFF, 1'b0);
    send_item(OpUpdate, 21'h1FFFFF, 1'b0);
    send_item(OpUpdate, 21'h000000, 1'b0);
  endtask

  // Two-button mode: menu press and release, and a partly held command key
  // carried over from normal mode.
  task automatic test_menu_button();
    write_mode(1'b1);
    send_item(OpUpdate, group_flag(ModCommand), 1'b0);
    send_item(OpUpdate, group_flag(ModCommand) | group_flag(ModControl)
                        | side_mask(ModControl, 1), 1'b0);
    send_item(OpUpdate, 21'h000000, 1'b0);
    write_mode(1'b0);
    send_item(OpUpdate, group_flag(ModCommand) | side_mask(ModCommand, 0), 1'b0);
    write_mode(1'b1);
    send_item(OpUpdate, group_flag(ModCommand) | side_mask(ModCommand, 0)
                        | side_mask(ModCommand, 1), 1'b0);
    send_item(OpUpdate, 21'h000000, 1'b0);
  endtask

  // Reset op with and without releases, including command held via the menu.
  task automatic test_reset_op();
    send_item(OpUpdate, 21'h1FFFFF, 1'b0);
    send_item(OpReset, 21'h1FFFFF, 1'b1);
    send_item(OpUpdate, group_flag(ModShift) | side_mask(ModShift, 0)
                        | group_flag(ModCommand), 1'b0);
    send_item(OpReset, 21'h000000, 1'b0);
    send_item(OpReset, 21'h0AAAAA, 1'b1);  // nothing held: marker only
  endtask

  // Receiver holds off for a long stretch while items keep coming back to back.
  task automatic test_backpressure();
    write_mode(1'b0);
    idle_on  = 1'b0;
    hold_off = 80;
    for (int i = 0; i < 12; i++)
      send_item(OpUpdate, (i % 2) ? 21'h000000 : 21'(($urandom | 21'h1E0000)), 1'b0);
    wait_drained();
    idle_on = 1'b1;
  endtask

  // Mostly well-formed flag words: group flags with full side masks, so held
  // state keeps changing; some noise bits, some arbitrary words, a few resets.
  task automatic test_random_items(int count);
    logic [20:0] flags;
    logic        op;
    logic        rel;
    for (int i = 0; i < count; i++) begin
      op    = OpUpdate;
      rel   = 1'($urandom_range(0, 1));
      flags = '0;
      if ($urandom_range(0, 99) < 6) begin
        op    = OpReset;
        flags = 21'($urandom);
      end else if ($urandom_range(0, 19) == 0) begin
        flags = 21'($urandom);
      end else begin
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(0, 1)) flags |= group_flag(k);
          if ($urandom_range(0, 9) < 6) flags |= side_mask(k, 0);
          if ($urandom_range(0, 9) < 6) flags |= side_mask(k, 1);
        end
        if ($urandom_range(0, 4) == 0) flags |= 21'($urandom);
      end
      send_item(op, flags, rel);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = OpUpdate;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    menu_mode   = 1'b0;
    idle_on     = 1'b1;
    hold_off    = 0;
    for (int k = 0; k < 4; k++) held_sides[k] = 2'b00;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_single_modifiers();
    test_flag_extremes();
    test_menu_button();
    test_reset_op();
    test_backpressure();

    // Random phases, alternating the mode; one phase runs without idling.
    for (int p = 0; p < 6; p++) begin
      write_mode(p[0]);
      idle_on = (p != 3);
      test_random_items(53);
    end
    idle_on = 1'b1;

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (pending_events.size() != 0) begin
      $error("%0d expected events never arrived", pending_events.size());
      errors++;
    end

    $display("run: %0d items (%0d resets), %0d events checked, %0d menu events",
             items_sent, reset_items, events_checked, menu_events);
    $display("run: %0d mode writes, both modes, one long output hold-off", cfg_writes);
    if (errors == 0) begin
      $display("modifier_flags_to_key_events_tb OK");
    end else begin
      $display("modifier_flags_to_key_events_tb NOT OK");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("modifier_flags_to_key_events_tb NOT OK");
    $finish;
  end

endmodule
